// ----- rtl/core/s16c_pkg.sv -----
package s16c_pkg;

  localparam int WORD_W        = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int MEM_DEPTH_DEF = 4096;
  localparam int MAX_CHAIN_DEF = 16;

  localparam logic [1:0] OP_WR_MEM = 2'd0;
  localparam logic [1:0] OP_WR_REG = 2'd1;
  localparam logic [1:0] OP_SET_PC = 2'd2;
  localparam logic [1:0] OP_STEP   = 2'd3;

  localparam logic [1:0] ST_WRITE  = 2'd0;
  localparam logic [1:0] ST_STEP   = 2'd1;
  localparam logic [1:0] ST_PC_OOR = 2'd2;
  localparam logic [1:0] ST_CHAIN  = 2'd3;

  localparam logic [1:0] FMT_IMM    = 2'd1;
  localparam logic [1:0] FMT_BRANCH = 2'd2;
  localparam logic [1:0] FMT_MEM    = 2'd3;

  localparam logic [1:0] COND_NEVER = 2'd3;

  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_AND = 3'd2;
  localparam logic [2:0] ALU_OR  = 3'd3;
  localparam logic [2:0] ALU_XOR = 3'd4;
  localparam logic [2:0] ALU_SHL = 3'd5;
  localparam logic [2:0] ALU_SHR = 3'd6;
  localparam logic [2:0] ALU_CMP = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAD,
    S_PCHK,
    S_FETCH,
    S_OPA,
    S_OPB,
    S_EXEC,
    S_LOAD,
    S_CHK,
    S_CHAIN,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/s16c_ram.sv -----
module s16c_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/s16c_alu.sv -----
module s16c_alu
  import s16c_pkg::*;
(
  input  logic [2:0]        sel,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] r
);

  always_comb begin
    case (sel)
      ALU_ADD: r = a + b;
      ALU_SUB: r = a - b;
      ALU_AND: r = a & b;
      ALU_OR:  r = a | b;
      ALU_XOR: r = a ^ b;
      ALU_SHL: r = a << b[3:0];
      ALU_SHR: r = a >> b[3:0];
      ALU_CMP: begin
        if (a == b) begin
          r = WORD_W'(0);
        end else if (a > b) begin
          r = WORD_W'(1);
        end else begin
          r = WORD_W'(2);
        end
      end
      default: r = '0;
    endcase
  end

endmodule

// ----- rtl/core/small_16bit_cpu_step.sv -----
// Write and set-pc items, and a step with pc out of range, go straight to the done state.
// Other steps first follow a leading branch and fetch the word it points to (ending the item
// if pc leaves the range), then read both operands, execute, finish a load and follow each
// trailing branch while pc stays in range. One item is in work at a time and input stall
// stays high until the result word is loaded into the output register.
// Reset is synchronous: registers, pc and last result clear, then memory clears word by word.
module small_16bit_cpu_step
  import s16c_pkg::*;
#(
  parameter int MEM_DEPTH        = MEM_DEPTH_DEF,
  parameter int MAX_BRANCH_CHAIN = MAX_CHAIN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [WORD_W-1:0] in_address,
  input  logic [WORD_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_executed_word,
  output logic [WORD_W-1:0] out_result_value,
  output logic [WORD_W-1:0] out_next_pc,
  output logic [1:0]        out_status
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CW = $clog2(MAX_BRANCH_CHAIN + 1);
  localparam logic [WORD_W:0] DEPTH_W = (WORD_W + 1)'(MEM_DEPTH);
  localparam logic [CW-1:0]   MAX_C   = CW'(MAX_BRANCH_CHAIN);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [WORD_W-1:0]   pc_r, pc_nxt;
  logic [WORD_W-1:0]   last_r, last_nxt;
  logic [WORD_W-1:0]   rf_r [NUM_REGS];
  logic [WORD_W-1:0]   rf_nxt [NUM_REGS];
  logic [WORD_W-1:0]   ir_r, ir_nxt;
  logic [WORD_W-1:0]   exec_word_r, exec_word_nxt;
  logic [WORD_W-1:0]   opa_r, opa_nxt;
  logic [WORD_W-1:0]   opb_r, opb_nxt;
  logic [WORD_W-1:0]   result_r, result_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [CW-1:0]       chain_cnt_r, chain_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_exec_r, out_exec_nxt;
  logic [WORD_W-1:0]   out_result_r, out_result_nxt;
  logic [WORD_W-1:0]   out_pc_r, out_pc_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [REG_IDX_W-1:0] rf_rd_idx;
  logic [WORD_W-1:0]   rf_rd;
  logic [WORD_W-1:0]   alu_r;
  logic [WORD_W-1:0]   imm;
  logic [WORD_W-1:0]   br_pc;
  logic                pc_ok;
  logic                out_free;

  s16c_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  s16c_alu u_alu (
    .sel (ir_r[4:2]),
    .a   (opa_r),
    .b   (opb_r),
    .r   (alu_r)
  );

  assign rf_rd_idx = (state_r == S_OPB) ? ir_r[12:10] : ir_r[15:13];
  assign rf_rd    = rf_r[rf_rd_idx];
  assign imm      = {{8{ir_r[12]}}, ir_r[12:5]};
  assign pc_ok    = {1'b0, pc_r} < DEPTH_W;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    br_pc = pc_r + WORD_W'(1);
    if (ram_rdata[3:2] != COND_NEVER && last_r == {14'd0, ram_rdata[3:2]}) begin
      br_pc = {4'd0, ram_rdata[15:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      pc_r         <= '0;
      last_r       <= '0;
      chain_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      pc_r         <= pc_nxt;
      last_r       <= last_nxt;
      chain_cnt_r  <= chain_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= rf_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    ir_r         <= ir_nxt;
    exec_word_r  <= exec_word_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    result_r     <= result_nxt;
    status_r     <= status_nxt;
    out_exec_r   <= out_exec_nxt;
    out_result_r <= out_result_nxt;
    out_pc_r     <= out_pc_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    pc_nxt         = pc_r;
    last_nxt       = last_r;
    rf_nxt         = rf_r;
    ir_nxt         = ir_r;
    exec_word_nxt  = exec_word_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    result_nxt     = result_r;
    status_nxt     = status_r;
    chain_cnt_nxt  = chain_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_exec_nxt   = out_exec_r;
    out_result_nxt = out_result_r;
    out_pc_nxt     = out_pc_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_cnt_r;
    ram_wdata      = '0;
    ram_raddr      = pc_r[AW-1:0];

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          exec_word_nxt = '0;
          result_nxt    = '0;
          status_nxt    = ST_WRITE;
          state_nxt     = S_DONE;
          case (in_operation)
            OP_WR_MEM: begin
              if ({1'b0, in_address} < DEPTH_W) begin
                ram_we    = 1'b1;
                ram_waddr = in_address[AW-1:0];
                ram_wdata = in_data;
              end
            end
            OP_WR_REG: begin
              if (in_address < WORD_W'(NUM_REGS)) begin
                rf_nxt[in_address[REG_IDX_W-1:0]] = in_data;
              end
            end
            OP_SET_PC: begin
              pc_nxt = in_address;
            end
            default: begin
              if (!pc_ok) begin
                status_nxt = ST_PC_OOR;
              end else begin
                state_nxt = S_LEAD;
              end
            end
          endcase
        end
      end
      S_LEAD: begin
        exec_word_nxt = ram_rdata;
        if (ram_rdata[1:0] == FMT_BRANCH) begin
          pc_nxt    = br_pc;
          state_nxt = S_PCHK;
        end else begin
          ir_nxt    = ram_rdata;
          state_nxt = S_OPA;
        end
      end
      S_PCHK: begin
        if (pc_ok) begin
          state_nxt = S_FETCH;
        end else begin
          status_nxt = ST_PC_OOR;
          state_nxt  = S_DONE;
        end
      end
      S_FETCH: begin
        ir_nxt    = ram_rdata;
        state_nxt = S_OPA;
      end
      S_OPA: begin
        opa_nxt   = rf_rd;
        state_nxt = S_OPB;
      end
      S_OPB: begin
        opb_nxt   = (ir_r[1:0] == FMT_IMM) ? imm : rf_rd;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        chain_cnt_nxt = '0;
        pc_nxt        = pc_r + WORD_W'(1);
        status_nxt    = ST_STEP;
        state_nxt     = S_CHK;
        if (ir_r[1:0] == FMT_MEM) begin
          ram_raddr = opb_r[AW-1:0];
          if ({1'b0, opb_r} >= DEPTH_W) begin
            result_nxt = '0;
          end else if (!ir_r[2]) begin
            state_nxt = S_LOAD;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = opb_r[AW-1:0];
            ram_wdata  = opa_r;
            result_nxt = opa_r;
          end
        end else begin
          rf_nxt[ir_r[15:13]] = alu_r;
          last_nxt            = alu_r;
          result_nxt          = alu_r;
        end
      end
      S_LOAD: begin
        rf_nxt[ir_r[15:13]] = ram_rdata;
        last_nxt            = ram_rdata;
        result_nxt          = ram_rdata;
        state_nxt           = S_CHK;
      end
      S_CHK: begin
        state_nxt = pc_ok ? S_CHAIN : S_DONE;
      end
      S_CHAIN: begin
        if (ram_rdata[1:0] != FMT_BRANCH) begin
          state_nxt = S_DONE;
        end else if (chain_cnt_r >= MAX_C) begin
          status_nxt = ST_CHAIN;
          state_nxt  = S_DONE;
        end else begin
          pc_nxt        = br_pc;
          chain_cnt_nxt = chain_cnt_r + CW'(1);
          state_nxt     = S_CHK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_exec_nxt   = exec_word_r;
          out_result_nxt = result_r;
          out_pc_nxt     = pc_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_executed_word = out_exec_r;
  assign out_result_value  = out_result_r;
  assign out_next_pc       = out_pc_r;
  assign out_status        = out_status_r;

`ifndef NO_ASSERTIONS
  a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chain_cnt_r <= MAX_C)
    else $error("Branch chain count exceeds its limit.");

  a_chain_pc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHAIN |-> pc_ok)
    else $error("Chain word read with the program counter out of range.");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r)
    else $error("Result word offered during the clearing pass.");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("Finished item did not reach the output register.");
`endif

endmodule
